[hdl/tbs_pkg.sv]
// tbs_pkg: shared constants, codes and types of the token bucket shaper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ID_BITS     = 16;
    localparam int LEVEL_W     = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = ID_BITS + LEVEL_W;

    localparam logic [LEVEL_W-1:0] DEPTH_RESET = LEVEL_W'(10);

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_ARRIVAL = 1'b1;

    typedef enum logic [1:0] {
        DROP_NONE = 2'd0,
        DROP_NEED = 2'd1,
        DROP_FULL = 2'd2
    } t_drop;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic cfg_wr;
    } t_ctrl;

endpackage

`default_nettype wire

[hdl/tbs_ram.sv]
// tbs_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/tbs_ctrl.sv]
// tbs_ctrl: item sequencer of the token bucket shaper
// depends on tbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module tbs_ctrl
    import tbs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire logic  i_cmd,
    input  wire logic  i_cfg_valid,
    output logic       busy,
    output logic       o_cfg_ready,
    output logic       o_result_valid,
    output t_ctrl      o_ctrl
);

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctrl.capture = 1'b1;
                    n_state = (i_cmd == CMD_ARRIVAL) ? S_EXEC : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_ctrl.cfg_wr = i_cfg_valid && (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_ctrl.exec;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_result_valid = r_done;

endmodule

`default_nettype wire

[hdl/tbs_dp.sv]
// tbs_dp: bucket level, depth register, packet queue and result registers
// depends on tbs_pkg and tbs_ram
`timescale 1ns / 1ps
`default_nettype none

module tbs_dp
    import tbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ctrl              i_ctrl,
    input  wire logic               i_cmd,
    input  wire logic [ID_BITS-1:0] i_packet_id,
    input  wire logic [LEVEL_W-1:0] i_tokens_needed,
    input  wire logic [LEVEL_W-1:0] i_cfg_data,
    output logic                    o_forwarded,
    output logic [ID_BITS-1:0]      o_forwarded_id,
    output logic [1:0]              o_packet_drop,
    output logic                    o_token_dropped,
    output logic [LEVEL_W-1:0]      o_bucket_level,
    output logic [CNT_W-1:0]        o_queue_count
);

    logic [LEVEL_W-1:0] r_depth;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [ADDR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic [LEVEL_W-1:0] r_need;

    logic [ENTRY_W-1:0] w_head_entry;
    logic [ID_BITS-1:0] w_head_id;
    logic [LEVEL_W-1:0] w_head_need;
    logic [LEVEL_W-1:0] w_tick_level;
    logic               w_we;

    logic               n_fwd;
    logic [ID_BITS-1:0] n_fwd_id;
    t_drop              n_drop;
    logic               n_tdrop;

    tbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata ({r_id, r_need}),
        .i_raddr (r_head),
        .o_rdata (w_head_entry)
    );

    assign w_head_id    = w_head_entry[ENTRY_W-1:LEVEL_W];
    assign w_head_need  = w_head_entry[LEVEL_W-1:0];
    assign w_tick_level = (r_level < r_depth) ? r_level + LEVEL_W'(1) : r_level;

    always_comb begin
        n_level  = r_level;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_fwd    = 1'b0;
        n_fwd_id = '0;
        n_drop   = DROP_NONE;
        n_tdrop  = 1'b0;
        w_we     = 1'b0;
        if (r_cmd == CMD_TICK) begin
            n_tdrop = !(r_level < r_depth);
            n_level = w_tick_level;
            if (r_count != '0 && w_tick_level >= w_head_need) begin
                n_level  = w_tick_level - w_head_need;
                n_fwd    = 1'b1;
                n_fwd_id = w_head_id;
                n_head   = (r_head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + ADDR_W'(1);
                n_count  = r_count - CNT_W'(1);
            end
        end else begin
            if (r_need > r_depth) begin
                n_drop = DROP_NEED;
            end else if (r_count == '0 && r_level >= r_need) begin
                n_level  = r_level - r_need;
                n_fwd    = 1'b1;
                n_fwd_id = r_id;
            end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                n_drop = DROP_FULL;
            end else begin
                w_we    = i_ctrl.exec;
                n_tail  = (r_tail == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + ADDR_W'(1);
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_RESET;
            r_level <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.cfg_wr) begin
                r_depth <= i_cfg_data;
            end
            if (i_ctrl.exec) begin
                r_level <= n_level;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd  <= i_cmd;
            r_id   <= i_packet_id;
            r_need <= i_tokens_needed;
        end
        if (i_ctrl.exec) begin
            o_forwarded     <= n_fwd;
            o_forwarded_id  <= n_fwd_id;
            o_packet_drop   <= n_drop;
            o_token_dropped <= n_tdrop;
            o_bucket_level  <= n_level;
            o_queue_count   <= n_count;
        end
    end

endmodule

`default_nettype wire

[hdl/token_bucket_shaper.sv]
// token_bucket_shaper: top level, sequencer plus datapath
// depends on tbs_pkg, tbs_ctrl, tbs_dp, tbs_ram
//
// channel   signals                                              handshake
// item in   i_cmd, i_packet_id, i_tokens_needed                  start & !busy
// result    o_forwarded, o_forwarded_id, o_packet_drop,          o_result_valid, one cycle
//           o_token_dropped, o_bucket_level, o_queue_count
// config    i_cfg_data (bucket depth)                            i_cfg_valid & o_cfg_ready
//
// a token tick passes from accept through S_FETCH and S_EXEC to the result strobe, a packet arrival through S_EXEC only
// S_FETCH covers the registered read of the queue head from the ram
// busy falls in the cycle the result is strobed, so a new item can be accepted there
// synchronous active-low reset empties the queue, zeroes the level, sets depth to 10
// results cannot be stalled; config is taken only while busy is low
`timescale 1ns / 1ps
`default_nettype none

module token_bucket_shaper
    import tbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cmd,
    input  wire logic [ID_BITS-1:0] i_packet_id,
    input  wire logic [LEVEL_W-1:0] i_tokens_needed,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LEVEL_W-1:0] i_cfg_data,
    output logic                    o_result_valid,
    output logic                    o_forwarded,
    output logic [ID_BITS-1:0]      o_forwarded_id,
    output logic [1:0]              o_packet_drop,
    output logic                    o_token_dropped,
    output logic [LEVEL_W-1:0]      o_bucket_level,
    output logic [CNT_W-1:0]        o_queue_count
);

    t_ctrl w_ctrl;

    tbs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .i_cfg_valid    (i_cfg_valid),
        .busy           (busy),
        .o_cfg_ready    (o_cfg_ready),
        .o_result_valid (o_result_valid),
        .o_ctrl         (w_ctrl)
    );

    tbs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_cmd           (i_cmd),
        .i_packet_id     (i_packet_id),
        .i_tokens_needed (i_tokens_needed),
        .i_cfg_data      (i_cfg_data),
        .o_forwarded     (o_forwarded),
        .o_forwarded_id  (o_forwarded_id),
        .o_packet_drop   (o_packet_drop),
        .o_token_dropped (o_token_dropped),
        .o_bucket_level  (o_bucket_level),
        .o_queue_count   (o_queue_count)
    );

endmodule

`default_nettype wire

[hdl/tbs_checker.sv]
// tbs_checker: port-level assertions for the token bucket shaper, bound to the top level
// depends on tbs_pkg and token_bucket_shaper
`timescale 1ns / 1ps
`default_nettype none

module tbs_checker
    import tbs_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_result_valid,
    input wire logic               o_forwarded,
    input wire logic [ID_BITS-1:0] o_forwarded_id,
    input wire logic [1:0]         o_packet_drop,
    input wire logic               o_token_dropped,
    input wire logic [CNT_W-1:0]   o_queue_count
);

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_result_valid))
        else $error("item accepted but block not busy next cycle");

    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobed while still busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_queue_count <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond queue depth");

    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_forwarded) |-> (o_forwarded_id == '0))
        else $error("forwarded id nonzero without a forward");

    a_drop_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_packet_drop != DROP_NONE) |-> (!o_forwarded && !o_token_dropped))
        else $error("packet drop together with forward or token drop");

endmodule

bind token_bucket_shaper tbs_checker u_tbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_forwarded    (o_forwarded),
    .o_forwarded_id (o_forwarded_id),
    .o_packet_drop  (o_packet_drop),
    .o_token_dropped(o_token_dropped),
    .o_queue_count  (o_queue_count)
);

`default_nettype wire
